// File: src/svang_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_pkg: shared constants and types of the signed vector angle block
// Holds the coordinate and datapath widths, the CORDIC arctangent table and
// the word that moves between the front end, the CORDIC chain and the back end.
// ----------------------------------------------------------------------------
package svang_pkg;

  // Coordinate width of every input field and the number of CORDIC steps.
  localparam int COORD_WIDTH  = 24;
  localparam int CORDIC_STEPS = 16;

  // The arctangent table has this many entries; more steps are not run.
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_COUNT   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  // Products are exact; above 56 bits they are scaled down toward zero.
  localparam int PROD_WIDTH = 2 * COORD_WIDTH;
  localparam int PROD_SHIFT = (PROD_WIDTH > 56) ? (PROD_WIDTH - 56) : 0;
  localparam int TERM_WIDTH = PROD_WIDTH - PROD_SHIFT;
  localparam int SUM_WIDTH  = TERM_WIDTH + 1;

  // CORDIC vector components carry two guard bits for the gain and rotation.
  localparam int VEC_WIDTH = SUM_WIDTH + 2;

  // Angle accumulator in Q30 radians, and the Q3.13 result.
  localparam int ANG_WIDTH   = 34;
  localparam int ANGLE_WIDTH = 16;
  localparam int ROUND_SHIFT = 17;

  localparam int HALF_PI_Q30 = 1686629713;
  localparam int PI_Q13      = 25736;

  // atan(2^-i) * 2^30, truncated.
  localparam int ATAN_Q30 [ATAN_ENTRIES] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  // One word of the CORDIC chain: vector, accumulated angle and zero flag.
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] d;
    logic signed [VEC_WIDTH-1:0] c;
    logic signed [ANG_WIDTH-1:0] z;
    logic                        degenerate;
  } cordic_word_t;

endpackage

// File: src/svang_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_if: valid/ready channels of the signed vector angle block
// svang_in_if carries a pair of vectors, svang_out_if carries one angle word.
// ----------------------------------------------------------------------------
interface svang_in_if import svang_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface svang_out_if import svang_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;
  logic                          degenerate;

  modport source (output valid, angle, degenerate, input ready);
  modport sink   (input valid, angle, degenerate, output ready);
endinterface

// File: src/svang_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_front: products, dot/cross sums and quadrant pre-rotation
// Stage one forms the four coordinate products and the zero-vector flag.
// Stage two sums them into dot and cross products and folds the left
// half-plane onto the right one, seeding the angle with plus or minus pi/2.
// ----------------------------------------------------------------------------
module svang_front import svang_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  svang_in_if.sink     vectors,
  output logic         out_valid,
  input  logic         out_ready,
  output cordic_word_t out_word
);

  localparam logic signed [PROD_WIDTH-1:0] PROD_BIAS =
    PROD_WIDTH'((64'd1 << PROD_SHIFT) - 64'd1);

  // Division by the product scale, truncating toward zero.
  function automatic logic signed [TERM_WIDTH-1:0] trunc_scale(
    input logic signed [PROD_WIDTH-1:0] p
  );
    logic signed [PROD_WIDTH-1:0] biased;
    biased = p[PROD_WIDTH-1] ? (p + PROD_BIAS) : p;
    return TERM_WIDTH'(biased >>> PROD_SHIFT);
  endfunction

  logic                         s1_valid;
  logic                         s1_ready;
  logic signed [PROD_WIDTH-1:0] p_xx;
  logic signed [PROD_WIDTH-1:0] p_yy;
  logic signed [PROD_WIDTH-1:0] p_xy;
  logic signed [PROD_WIDTH-1:0] p_yx;
  logic                         s1_degenerate;

  logic                         s2_valid;
  logic                         s2_ready;
  cordic_word_t                 s2_word;
  cordic_word_t                 word_next;

  logic                         zero_first;
  logic                         zero_second;

  // A stage takes a new word when it is empty or its word moves on.
  assign s2_ready      = !s2_valid || out_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign vectors.ready = s1_ready;

  assign zero_first  = (vectors.first_x == '0) && (vectors.first_y == '0);
  assign zero_second = (vectors.second_x == '0) && (vectors.second_y == '0);

  // Stage one valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= vectors.valid;
    end
  end

  // Stage one products.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      p_xx          <= PROD_WIDTH'(vectors.first_x) * PROD_WIDTH'(vectors.second_x);
      p_yy          <= PROD_WIDTH'(vectors.first_y) * PROD_WIDTH'(vectors.second_y);
      p_xy          <= PROD_WIDTH'(vectors.first_x) * PROD_WIDTH'(vectors.second_y);
      p_yx          <= PROD_WIDTH'(vectors.first_y) * PROD_WIDTH'(vectors.second_x);
      s1_degenerate <= zero_first || zero_second;
    end
  end

  // Dot and cross sums, then the fold into the right half-plane.
  always_comb begin
    logic signed [SUM_WIDTH-1:0] dot_sum;
    logic signed [SUM_WIDTH-1:0] cross_sum;
    logic signed [VEC_WIDTH-1:0] dot_ext;
    logic signed [VEC_WIDTH-1:0] cross_ext;
    dot_sum   = SUM_WIDTH'(trunc_scale(p_xx)) + SUM_WIDTH'(trunc_scale(p_yy));
    cross_sum = SUM_WIDTH'(trunc_scale(p_xy)) - SUM_WIDTH'(trunc_scale(p_yx));
    dot_ext   = VEC_WIDTH'(dot_sum);
    cross_ext = VEC_WIDTH'(cross_sum);
    word_next.degenerate = s1_degenerate;
    if (!dot_ext[VEC_WIDTH-1]) begin
      word_next.d = dot_ext;
      word_next.c = cross_ext;
      word_next.z = '0;
    end else if (!cross_ext[VEC_WIDTH-1]) begin
      word_next.d = cross_ext;
      word_next.c = -dot_ext;
      word_next.z = ANG_WIDTH'(HALF_PI_Q30);
    end else begin
      word_next.d = -cross_ext;
      word_next.c = dot_ext;
      word_next.z = -ANG_WIDTH'(HALF_PI_Q30);
    end
  end

  // Stage two valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // Stage two word.
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_word <= word_next;
    end
  end

  assign out_valid = s2_valid;
  assign out_word  = s2_word;

endmodule

// File: src/svang_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_cordic: unrolled CORDIC vectoring chain
// One register stage per iteration; each stage turns the vector toward the
// positive x axis by atan(2^-i) and accumulates the angle it turned.
// ----------------------------------------------------------------------------
module svang_cordic import svang_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cordic_word_t in_word,
  output logic         out_valid,
  input  logic         out_ready,
  output cordic_word_t out_word
);

  logic [STEP_COUNT-1:0] stage_valid;
  logic [STEP_COUNT-1:0] stage_ready;
  cordic_word_t          stage_word [STEP_COUNT];

  genvar k;
  generate
    for (k = 0; k < STEP_COUNT; k++) begin : g_step
      cordic_word_t src;
      cordic_word_t step_next;
      logic         src_valid;
      logic         down_ready;

      // Word and valid bit entering this stage.
      if (k == 0) begin : g_first
        assign src       = in_word;
        assign src_valid = in_valid;
      end else begin : g_inner
        assign src       = stage_word[k-1];
        assign src_valid = stage_valid[k-1];
      end

      // Ready of the stage that follows.
      if (k == STEP_COUNT - 1) begin : g_last
        assign down_ready = out_ready;
      end else begin : g_mid
        assign down_ready = stage_ready[k+1];
      end

      assign stage_ready[k] = !stage_valid[k] || down_ready;

      // One vectoring iteration with floor shifts.
      always_comb begin
        logic signed [VEC_WIDTH-1:0] ds;
        logic signed [VEC_WIDTH-1:0] cs;
        ds = src.d >>> k;
        cs = src.c >>> k;
        step_next.degenerate = src.degenerate;
        if (!src.c[VEC_WIDTH-1]) begin
          step_next.d = src.d + cs;
          step_next.c = src.c - ds;
          step_next.z = src.z + ANG_WIDTH'(ATAN_Q30[k]);
        end else begin
          step_next.d = src.d - cs;
          step_next.c = src.c + ds;
          step_next.z = src.z - ANG_WIDTH'(ATAN_Q30[k]);
        end
      end

      // Stage valid bit.
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[k] <= 1'b0;
        end else if (stage_ready[k]) begin
          stage_valid[k] <= src_valid;
        end
      end

      // Stage word.
      always_ff @(posedge clk) begin
        if (stage_ready[k]) begin
          stage_word[k] <= step_next;
        end
      end
    end
  endgenerate

  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[STEP_COUNT-1];
  assign out_word  = stage_word[STEP_COUNT-1];

endmodule

// File: src/svang_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_back: rounding, saturation and the output register
// Rounds the Q30 angle to Q3.13, clamps it to plus or minus pi and forces
// zero for a degenerate pair.
// ----------------------------------------------------------------------------
module svang_back import svang_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cordic_word_t in_word,
  svang_out_if.source  result
);

  localparam logic signed [ANG_WIDTH-1:0] ROUND_BIAS = ANG_WIDTH'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [ANG_WIDTH-1:0] PI_LIMIT   = ANG_WIDTH'(PI_Q13);

  logic                          out_valid;
  logic signed [ANGLE_WIDTH-1:0] out_angle;
  logic                          out_degenerate;
  logic signed [ANGLE_WIDTH-1:0] angle_next;

  assign in_ready = !out_valid || result.ready;

  // Round half up, floor shift, then clamp.
  always_comb begin
    logic signed [ANG_WIDTH-1:0] rounded;
    rounded = (in_word.z + ROUND_BIAS) >>> ROUND_SHIFT;
    if (in_word.degenerate) begin
      angle_next = '0;
    end else if (rounded > PI_LIMIT) begin
      angle_next = ANGLE_WIDTH'(PI_LIMIT);
    end else if (rounded < -PI_LIMIT) begin
      angle_next = ANGLE_WIDTH'(-PI_LIMIT);
    end else begin
      angle_next = ANGLE_WIDTH'(rounded);
    end
  end

  // Output valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_angle      <= angle_next;
      out_degenerate <= in_word.degenerate;
    end
  end

  assign result.valid      = out_valid;
  assign result.angle      = out_angle;
  assign result.degenerate = out_degenerate;

endmodule

// File: src/signed_vector_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_vector_angle_top: signed angle from one 2D vector to another
// Dot and cross products feed an unrolled CORDIC that yields atan2(cross,
// dot) in Q3.13 radians; a zero vector gives angle 0 and the degenerate flag.
// ----------------------------------------------------------------------------
//
//   channel   role    word contents
//   -------   -----   ------------------------------------------------
//   vectors   sink    first_x, first_y, second_x, second_y (signed)
//   result    source  angle (signed Q3.13), degenerate
//
// One word is accepted every cycle while the result is not stalled; the
// pipeline has 2 + STEP_COUNT + 1 stages, one stage per CORDIC iteration
// setting that depth.
// Reset clears every valid bit; the datapath registers are not reset.
// A stalled result holds every stage behind it; empty stages keep filling,
// so no word is lost or repeated.
// ----------------------------------------------------------------------------
module signed_vector_angle_top import svang_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  svang_in_if.sink    vectors,
  svang_out_if.source result
);

  logic         front_valid;
  logic         front_ready;
  cordic_word_t front_word;

  logic         cordic_valid;
  logic         cordic_ready;
  cordic_word_t cordic_word;

  svang_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vectors   (vectors),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_word  (front_word)
  );

  svang_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_word   (front_word),
    .out_valid (cordic_valid),
    .out_ready (cordic_ready),
    .out_word  (cordic_word)
  );

  svang_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cordic_valid),
    .in_ready (cordic_ready),
    .in_word  (cordic_word),
    .result   (result)
  );

  // A degenerate pair always reports a zero angle.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.degenerate) |-> (result.angle == '0))
    else $error("degenerate result with nonzero angle");

  // The angle never leaves the range of plus or minus pi.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.angle <= 16'sd25736) && (result.angle >= -16'sd25736)))
    else $error("angle outside plus or minus pi");

  // The input side stalls only when the whole pipeline is held by the output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !vectors.ready |-> (result.valid && !result.ready))
    else $error("input stalled while output is free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
